// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the keypad entry design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KDE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keypad entry assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define KDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keypad entry assertion failed");

`endif

// ----- src/kde_pkg.sv -----
// ----------------------------------------------------------------------------
// kde_pkg
// Types, constants and decode tables for the keypad digit entry unit.
// ----------------------------------------------------------------------------
package kde_pkg;

    localparam int unsigned NUM_ROWS   = 4;
    localparam int unsigned COL_W      = 4;
    localparam int unsigned NUM_DIGITS = 4;
    localparam int unsigned CODE_W     = 5;
    localparam int unsigned KEY_W      = 4;
    localparam int unsigned SEG_W      = 8;
    localparam int unsigned SCAN_W     = 5;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [SEG_W-1:0]  t_seg;
    typedef logic [SCAN_W-1:0] t_scan;

    // Digit codes with special meaning
    localparam t_code CODE_BLANK = t_code'(16);
    localparam t_code CODE_DASH  = t_code'(17);

    // Key values of the non-digit keys
    localparam t_key KEY_STAR  = t_key'(14);
    localparam t_key KEY_SHARP = t_key'(15);
    localparam t_key KEY_A     = t_key'(10);
    localparam t_key KEY_B     = t_key'(11);
    localparam t_key KEY_C     = t_key'(12);
    localparam t_key KEY_D     = t_key'(13);

    // Scan codes: 0 no key, 1..16 single key, 17 several columns in a row
    localparam t_scan SCAN_NONE  = t_scan'(0);
    localparam t_scan SCAN_MULTI = t_scan'(17);

    // Decoded poll, passed from the scanner to the entry buffer
    typedef struct packed {
        logic present;
        t_key value;
    } t_key_evt;

    // Scan code to key value
    function automatic t_key map_key(input t_scan s);
        t_key k;
        case (s)
            t_scan'(1):  k = t_key'(1);
            t_scan'(2):  k = t_key'(2);
            t_scan'(3):  k = t_key'(3);
            t_scan'(4):  k = KEY_A;
            t_scan'(5):  k = t_key'(4);
            t_scan'(6):  k = t_key'(5);
            t_scan'(7):  k = t_key'(6);
            t_scan'(8):  k = KEY_B;
            t_scan'(9):  k = t_key'(7);
            t_scan'(10): k = t_key'(8);
            t_scan'(11): k = t_key'(9);
            t_scan'(12): k = KEY_C;
            t_scan'(13): k = KEY_STAR;
            t_scan'(14): k = t_key'(0);
            t_scan'(15): k = KEY_SHARP;
            t_scan'(16): k = KEY_D;
            SCAN_MULTI:  k = KEY_D;
            default:     k = t_key'(0);
        endcase
        return k;
    endfunction

    // Digit code to active-low segment pattern
    function automatic t_seg seg_of(input t_code c);
        t_seg p;
        case (c)
            t_code'(0):  p = 8'hc0;
            t_code'(1):  p = 8'hf9;
            t_code'(2):  p = 8'ha4;
            t_code'(3):  p = 8'hb0;
            t_code'(4):  p = 8'h99;
            t_code'(5):  p = 8'h92;
            t_code'(6):  p = 8'h82;
            t_code'(7):  p = 8'hd8;
            t_code'(8):  p = 8'h80;
            t_code'(9):  p = 8'h90;
            t_code'(10): p = 8'h88;
            t_code'(11): p = 8'h83;
            t_code'(12): p = 8'hc4;
            t_code'(13): p = 8'ha1;
            t_code'(14): p = 8'h84;
            t_code'(15): p = 8'h8e;
            CODE_BLANK:  p = 8'hff;
            CODE_DASH:   p = 8'hbf;
            default:     p = 8'hff;
        endcase
        return p;
    endfunction

endpackage

// ----- src/kde_if.sv -----
// ----------------------------------------------------------------------------
// kde_poll_if / kde_disp_if
// Valid/ready channels for matrix polls and display words.
// ----------------------------------------------------------------------------
interface kde_poll_if import kde_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] cols_row0;
    logic [COL_W-1:0] cols_row1;
    logic [COL_W-1:0] cols_row2;
    logic [COL_W-1:0] cols_row3;

    modport source (output valid, cols_row0, cols_row1, cols_row2, cols_row3,
                    input ready);
    modport sink   (input valid, cols_row0, cols_row1, cols_row2, cols_row3,
                    output ready);
endinterface

interface kde_disp_if import kde_pkg::*; ();
    logic  valid;
    logic  ready;
    t_code digit_code0;
    t_code digit_code1;
    t_code digit_code2;
    t_code digit_code3;
    t_seg  seg_pattern0;
    t_seg  seg_pattern1;
    t_seg  seg_pattern2;
    t_seg  seg_pattern3;
    t_key  key_value;
    logic  overflow;

    modport source (output valid, digit_code0, digit_code1, digit_code2, digit_code3,
                    seg_pattern0, seg_pattern1, seg_pattern2, seg_pattern3,
                    key_value, overflow,
                    input ready);
    modport sink   (input valid, digit_code0, digit_code1, digit_code2, digit_code3,
                    seg_pattern0, seg_pattern1, seg_pattern2, seg_pattern3,
                    key_value, overflow,
                    output ready);
endinterface

// ----- src/keypad_digit_entry_display_unit.sv -----
// ----------------------------------------------------------------------------
// keypad_digit_entry_display_unit
// 4x4 keypad poll decoder with four-digit entry buffer and segment encoder.
// ----------------------------------------------------------------------------
// One poll word is accepted per clock while the sink takes each display word,
// and each poll gives one display word. A poll is held in the input register,
// then decoded and folded into the digit buffer, whose registers also form the
// result; the display word becomes valid when the buffer registers load the
// decoded poll. While a finished word waits on the sink, one further poll is
// taken into the input register before ready drops.
`include "assert_macros.svh"

module keypad_digit_entry_display_unit import kde_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kde_poll_if.sink    i_poll,
    kde_disp_if.source  o_disp
);

    logic             r_in_valid;
    logic [COL_W-1:0] r_cols [NUM_ROWS];
    logic             r_out_valid;
    logic             adv;
    t_key_evt         key_evt;
    t_code            digit [NUM_DIGITS];
    t_key             last_key;
    logic             ovf;
    logic             released;
    logic             upper_clear;

    // Stage handshake
    assign adv          = r_in_valid && (!r_out_valid || o_disp.ready);
    assign i_poll.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_poll.ready) begin
                r_in_valid <= i_poll.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_disp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Poll word register
    always_ff @(posedge i_clk) begin
        if (i_poll.valid && i_poll.ready) begin
            r_cols[0] <= i_poll.cols_row0;
            r_cols[1] <= i_poll.cols_row1;
            r_cols[2] <= i_poll.cols_row2;
            r_cols[3] <= i_poll.cols_row3;
        end
    end

    kde_scan_decode u_scan (
        .i_cols (r_cols),
        .o_key  (key_evt)
    );

    kde_entry_buffer u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_key      (key_evt),
        .o_digit    (digit),
        .o_last_key (last_key),
        .o_overflow (ovf),
        .o_released (released)
    );

    // Display word
    assign o_disp.valid        = r_out_valid;
    assign o_disp.digit_code0  = digit[0];
    assign o_disp.digit_code1  = digit[1];
    assign o_disp.digit_code2  = digit[2];
    assign o_disp.digit_code3  = digit[3];
    assign o_disp.seg_pattern0 = seg_of(digit[0]);
    assign o_disp.seg_pattern1 = seg_of(digit[1]);
    assign o_disp.seg_pattern2 = seg_of(digit[2]);
    assign o_disp.seg_pattern3 = seg_of(digit[3]);
    assign o_disp.key_value    = last_key;
    assign o_disp.overflow     = ovf;

    // Upper three digits all zero
    assign upper_clear = (digit[3] == '0) && (digit[2] == '0) && (digit[1] == '0);

    // Overflow always leaves the upper three digits cleared
    `KDE_ASSERT_SAME(a_ovf_clears, i_clk, i_rst_n, ovf, upper_clear)
    // An empty poll marks the key as released
    `KDE_ASSERT_NEXT(a_release, i_clk, i_rst_n, adv && !key_evt.present, released)
    // Back-pressure only when both stages hold a word
    `KDE_ASSERT_SAME(a_ready_full, i_clk, i_rst_n, !i_poll.ready, r_in_valid && r_out_valid)

endmodule

// ----- src/kde_scan_decode.sv -----
// ----------------------------------------------------------------------------
// kde_scan_decode
// Finds the first active row of a poll and maps it to a key value.
// ----------------------------------------------------------------------------
module kde_scan_decode import kde_pkg::*; (
    input  logic [COL_W-1:0] i_cols [NUM_ROWS],
    output t_key_evt         o_key
);

    t_scan scan;

    // Priority over rows, row 0 first
    always_comb begin
        scan = SCAN_NONE;
        for (int r = NUM_ROWS - 1; r >= 0; r--) begin
            if (i_cols[r] != '0) begin
                case (i_cols[r])
                    4'b0001: scan = t_scan'(r * 4 + 1);
                    4'b0010: scan = t_scan'(r * 4 + 2);
                    4'b0100: scan = t_scan'(r * 4 + 3);
                    4'b1000: scan = t_scan'(r * 4 + 4);
                    default: scan = SCAN_MULTI;
                endcase
            end
        end
    end

    assign o_key.present = (scan != SCAN_NONE);
    assign o_key.value   = map_key(scan);

endmodule

// ----- src/kde_entry_buffer.sv -----
// ----------------------------------------------------------------------------
// kde_entry_buffer
// Four-digit entry buffer with release tracking and overflow flag.
// ----------------------------------------------------------------------------
module kde_entry_buffer import kde_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_key_evt i_key,
    output t_code    o_digit [NUM_DIGITS],
    output t_key     o_last_key,
    output logic     o_overflow,
    output logic     o_released
);

    t_code r_digit [NUM_DIGITS];
    t_code n_digit [NUM_DIGITS];
    logic  r_released, n_released;
    logic  r_overflow, n_overflow;
    t_key  r_last_key, n_last_key;

    // Buffer update for one poll
    always_comb begin
        n_digit    = r_digit;
        n_released = r_released;
        n_overflow = r_overflow;
        n_last_key = r_last_key;
        if (i_key.present) begin
            n_last_key = i_key.value;
            if (r_released) begin
                if (r_digit[3] != '0) begin
                    // full buffer: clear upper digits, flag overflow
                    n_digit[3] = '0;
                    n_digit[2] = '0;
                    n_digit[1] = '0;
                    n_overflow = 1'b1;
                end else begin
                    n_digit[3] = r_digit[2];
                    n_digit[2] = r_digit[1];
                    n_digit[1] = r_digit[0];
                    n_overflow = 1'b0;
                end
                n_released = 1'b0;
            end else begin
                n_digit[0] = r_overflow ? '0 : t_code'(i_key.value);
            end
        end else begin
            n_released = 1'b1;
        end
    end

    // State registers, loaded once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digit[i] <= CODE_DASH;
            end
            r_released <= 1'b0;
            r_overflow <= 1'b0;
            r_last_key <= '0;
        end else if (i_adv) begin
            r_digit    <= n_digit;
            r_released <= n_released;
            r_overflow <= n_overflow;
            r_last_key <= n_last_key;
        end
    end

    assign o_digit    = r_digit;
    assign o_last_key = r_last_key;
    assign o_overflow = r_overflow;
    assign o_released = r_released;

endmodule
